>>> rtl/vagcu_pkg.sv
// Package: shared types, operation codes and AES / GF(2^128) helper functions.
package vagcu_pkg;

   typedef enum logic [3:0] {
      OP_DEC_MID   = 4'd0,
      OP_DEC_FINAL = 4'd1,
      OP_ENC_MID   = 4'd2,
      OP_ENC_FINAL = 4'd3,
      OP_XOR_KEY   = 4'd4,
      OP_GMUL      = 4'd5,
      OP_GHASH     = 4'd6,
      OP_KEY128    = 4'd7,
      OP_KEY256    = 4'd8
   } op_type;

   localparam int DATA_W = 128;
   localparam int ROUND_W = 5;
   localparam int REQ_TDATA_W = 400;
   localparam int RSP_TDATA_W = 128;

   typedef struct packed {
      logic [3:0]   operation;
      logic [127:0] dest;
      logic [127:0] src2;
      logic [127:0] src1;
      logic [3:0]   rnd;
   } req_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] ISBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   localparam logic [7:0] RCON [10] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'd27,8'd54
   };

   function automatic logic [7:0] xtime(input logic [7:0] x);
      xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] rcon_of(input logic [3:0] idx);
      rcon_of = (idx < 4'd10) ? RCON[idx] : 8'h00;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] x);
      sub_word = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
   endfunction

   function automatic logic [127:0] brev8(input logic [127:0] x);
      logic [127:0] r;
      for (int i = 0; i < 128; i++) begin
         r[i] = x[(i & ~7) + 7 - (i & 7)];
      end
      brev8 = r;
   endfunction

endpackage

>>> rtl/vector_aes_ghash_crypto_unit.sv
// Top level: vector AES round, key schedule and GHASH unit with registered stream ports.
//
// One request word carries an operation, three 128-bit operands and a round number;
// each produces exactly one 128-bit response word. Operations cover AES decrypt and
// encrypt middle and final rounds, a key-addition-only round, the AES-128 and
// AES-256 key-schedule steps, the GCM multiply and a GHASH step. Unused codes give
// a zero result.
// The request is captured into an input register; the whole operation is evaluated
// by combinational logic between that register and the response register, which
// holds the response word until the receiver takes it.
// Throughput is one word per clock: the input register refills in the same cycle as
// it hands its word to the response register, and both advance whenever the response
// register is empty or is being emptied.
// When the receiver holds rsp_tready low, the response word stays put, the input
// register holds its word and req_tready falls only once both registers are full.
// A synchronous reset empties both registers; no other state exists.
module vector_aes_ghash_crypto_unit
   import vagcu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // operation[3:0], dest_lo, dest_hi, src2_lo, src2_hi, src1_lo, src1_hi,
   // round_number[4:0], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // result_lo[63:0], result_hi[127:64]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   req_type      req_ff, req_in;
   logic         req_valid_ff;
   logic         rsp_valid_ff;
   logic [127:0] rsp_ff, rsp_in;
   logic         advance;

   // Stage advances when the response slot is free or is being taken.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance || !req_valid_ff;

   always_comb begin
      req_in.operation = req_tdata[3:0];
      req_in.dest      = req_tdata[131:4];
      req_in.src2      = req_tdata[259:132];
      req_in.src1      = req_tdata[387:260];
      req_in.rnd       = req_tdata[391:388]; // bit 4 of round_number plays no part
   end

   logic [127:0] aes_out, gf_out, gf_y;
   logic [31:0]  k3, sw_rot, sw_plain, w0, w1, w2, w3;
   logic [127:0] key_base;
   logic [3:0]   rnd_a, rnd_b, rc_idx;
   logic         use_plain;

   vagcu_aes_round u_aes (
      .operation (req_ff.operation),
      .state     (req_ff.dest),
      .round_key (req_ff.src2),
      .result    (aes_out)
   );

   assign gf_y = (req_ff.operation == OP_GHASH) ? (req_ff.dest ^ req_ff.src1) : req_ff.dest;

   vagcu_gf_mul u_gf (
      .y     (gf_y),
      .h_in  (req_ff.src2),
      .z_out (gf_out)
   );

   // Key schedule: out-of-range rounds fold back by flipping bit 3.
   always_comb begin
      k3       = req_ff.src2[127:96];
      sw_rot   = sub_word({k3[7:0], k3[31:8]});
      sw_plain = sub_word(k3);
      rnd_a    = req_ff.rnd;
      if (rnd_a == 4'd0 || rnd_a > 4'd10) begin
         rnd_a = rnd_a ^ 4'd8;
      end
      rnd_b = req_ff.rnd;
      if (rnd_b < 4'd2 || rnd_b > 4'd14) begin
         rnd_b = rnd_b ^ 4'd8;
      end
      if (req_ff.operation == OP_KEY128) begin
         key_base  = req_ff.src2;
         use_plain = 1'b0;
         rc_idx    = rnd_a - 4'd1;
      end else begin
         key_base  = req_ff.dest;
         use_plain = rnd_b[0];
         rc_idx    = {1'b0, rnd_b[3:1]} - 4'd1;
      end
      w0 = (use_plain ? sw_plain : (sw_rot ^ {24'h0, rcon_of(rc_idx)})) ^ key_base[31:0];
      w1 = w0 ^ key_base[63:32];
      w2 = w1 ^ key_base[95:64];
      w3 = w2 ^ key_base[127:96];
   end

   always_comb begin
      case (req_ff.operation) inside
         OP_DEC_MID, OP_DEC_FINAL, OP_ENC_MID, OP_ENC_FINAL, OP_XOR_KEY: rsp_in = aes_out;
         OP_GMUL, OP_GHASH:    rsp_in = gf_out;
         OP_KEY128, OP_KEY256: rsp_in = {w3, w2, w1, w0};
         default:              rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
      end
      if (advance && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
      if (req_tready && req_tvalid) begin
         req_ff <= req_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

`ifndef SYNTHESIS
   // A held response word must not change while the receiver stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("response word changed under stall");
   // A buffered request is never dropped: it reaches the response register next.
   a_req_moves: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && advance |=> rsp_valid_ff)
      else $error("request lost between stages");
   // Ready only falls when both stages are occupied.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> req_valid_ff && rsp_valid_ff)
      else $error("input stalled with free space");
`endif

endmodule

>>> rtl/vagcu_aes_round.sv
// AES round datapath: shift rows, substitution, mix columns and key addition.
module vagcu_aes_round
   import vagcu_pkg::*;
(
   input  logic [3:0]   operation,
   input  logic [127:0] state,
   input  logic [127:0] round_key,
   output logic [127:0] result
);

   logic [127:0] inv_sr, inv_sb, dec_x, dec_mc;
   logic [127:0] fwd_sb, fwd_sr, enc_mc;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            inv_sr[(4*c+r)*8 +: 8] = state[(4*((c+4-r)&3)+r)*8 +: 8];
            fwd_sb[(4*c+r)*8 +: 8] = SBOX[state[(4*c+r)*8 +: 8]];
         end
      end
      for (int k = 0; k < 16; k++) begin
         inv_sb[k*8 +: 8] = ISBOX[inv_sr[k*8 +: 8]];
      end
      dec_x = inv_sb ^ round_key;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            fwd_sr[(4*c+r)*8 +: 8] = fwd_sb[(4*((c+r)&3)+r)*8 +: 8];
         end
      end
      for (int c = 0; c < 4; c++) begin
         logic [7:0] a0, a1, a2, a3, e0, e1, d0, d1, f0, f1, f2, f3;
         a0 = dec_x[(4*c)*8 +: 8];   a1 = dec_x[(4*c+1)*8 +: 8];
         a2 = dec_x[(4*c+2)*8 +: 8]; a3 = dec_x[(4*c+3)*8 +: 8];
         // Inverse mix via the standard decomposition: pre-multiply then forward mix.
         e0 = xtime(xtime(a0 ^ a2)); e1 = xtime(xtime(a1 ^ a3));
         a0 = a0 ^ e0; a2 = a2 ^ e0; a1 = a1 ^ e1; a3 = a3 ^ e1;
         d0 = a0 ^ a1 ^ a2 ^ a3;
         dec_mc[(4*c)*8 +: 8]   = a0 ^ d0 ^ xtime(a0 ^ a1);
         dec_mc[(4*c+1)*8 +: 8] = a1 ^ d0 ^ xtime(a1 ^ a2);
         dec_mc[(4*c+2)*8 +: 8] = a2 ^ d0 ^ xtime(a2 ^ a3);
         dec_mc[(4*c+3)*8 +: 8] = a3 ^ d0 ^ xtime(a3 ^ a0);
         f0 = fwd_sr[(4*c)*8 +: 8];   f1 = fwd_sr[(4*c+1)*8 +: 8];
         f2 = fwd_sr[(4*c+2)*8 +: 8]; f3 = fwd_sr[(4*c+3)*8 +: 8];
         d1 = f0 ^ f1 ^ f2 ^ f3;
         enc_mc[(4*c)*8 +: 8]   = f0 ^ d1 ^ xtime(f0 ^ f1);
         enc_mc[(4*c+1)*8 +: 8] = f1 ^ d1 ^ xtime(f1 ^ f2);
         enc_mc[(4*c+2)*8 +: 8] = f2 ^ d1 ^ xtime(f2 ^ f3);
         enc_mc[(4*c+3)*8 +: 8] = f3 ^ d1 ^ xtime(f3 ^ f0);
      end
   end

   always_comb begin
      case (operation)
         OP_DEC_MID:   result = dec_mc;
         OP_DEC_FINAL: result = dec_x;
         OP_ENC_MID:   result = enc_mc ^ round_key;
         OP_ENC_FINAL: result = fwd_sr ^ round_key;
         default:      result = state ^ round_key;
      endcase
   end

endmodule

>>> rtl/vagcu_gf_mul.sv
// GF(2^128) multiplier with the 0x87 reduction on byte-wise bit-reversed operands.
module vagcu_gf_mul
   import vagcu_pkg::*;
(
   input  logic [127:0] y,
   input  logic [127:0] h_in,
   output logic [127:0] z_out
);

   logic [127:0] s, h, z;

   // Each bit of s gates an independent shifted copy of h; the shifts are fixed wiring.
   always_comb begin
      s = brev8(y);
      h = brev8(h_in);
      z = '0;
      for (int b = 0; b < 128; b++) begin
         if (s[b]) begin
            z = z ^ h;
         end
         h = {h[126:0], 1'b0} ^ (h[127] ? 128'h87 : 128'h0);
      end
      z_out = brev8(z);
   end

endmodule
